/* hw/rtl/cost_matrix_reduction_defines.svh */
// ----------------------------------------------------------------------------
// Cost matrix reduction: assertion macros
// Shared shorthand for the concurrent checks in the queue and the back end.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COST_MATRIX_REDUCTION_DEFINES_SVH
`define COST_MATRIX_REDUCTION_DEFINES_SVH

// A condition that must hold at every clock edge.
`define CMR_CHECK(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define CMR_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define CMR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/cmr_pkg.sv */
// ----------------------------------------------------------------------------
// Cost matrix reduction package
// Sizes, command codes and the classified request that moves from the front
// end through the queue to the back end.
// ----------------------------------------------------------------------------
package cmr_pkg;

    // Matrix storage: MAX_SIZE rows and columns.
    localparam int MAX_SIZE = 16;
    localparam int CELL_N   = MAX_SIZE * MAX_SIZE;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = $clog2(MAX_SIZE + 1);
    localparam int ADDR_W   = $clog2(CELL_N);

    // Field widths of the request and result channels.
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 4;
    localparam int VALUE_W = 20;
    localparam int TOTAL_W = 26;
    localparam int SIZE_W  = 5;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(16);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes as they arrive on the cmd field.
    typedef enum logic [CMD_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_CROSS  = 2'd1,
        OP_REDUCE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // A request after decoding.
    typedef struct packed {
        t_op                 op;
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    col;
        logic                row_in;
        logic                col_in;
        logic [ADDR_W-1:0]   addr;
        logic [VALUE_W-1:0]  value;
        logic                entry_valid;
    } t_item;

endpackage

/* hw/rtl/cmr_front.sv */
// ----------------------------------------------------------------------------
// Cost matrix reduction: front end
// Takes requests from the input channel, decodes the command, checks the
// indices against the storage and forms the cell address for the queue.
// ----------------------------------------------------------------------------
module cmr_front import cmr_pkg::*; (
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [ROW_W-1:0]   i_row_index,
    input  logic [ROW_W-1:0]   i_col_index,
    input  logic [VALUE_W-1:0] i_entry_value,
    input  logic               i_entry_valid,
    input  logic               i_q_ready,
    output logic               o_q_push,
    output t_item              o_q_item
);

    logic row_in;
    logic col_in;

    // A request waits while the queue is full.
    assign o_in_stall = !i_q_ready;
    assign o_q_push   = i_in_valid && i_q_ready;

    // Indices beyond the storage are flagged; their address is never used.
    assign row_in = int'(i_row_index) < MAX_SIZE;
    assign col_in = int'(i_col_index) < MAX_SIZE;

    always_comb begin
        o_q_item.op          = t_op'(i_cmd);
        o_q_item.row         = i_row_index;
        o_q_item.col         = i_col_index;
        o_q_item.row_in      = row_in;
        o_q_item.col_in      = col_in;
        o_q_item.addr        = ADDR_W'(ADDR_W'(i_row_index) * ADDR_W'(MAX_SIZE)
                                       + ADDR_W'(i_col_index));
        o_q_item.value       = i_entry_value;
        o_q_item.entry_valid = i_entry_valid;
    end

endmodule

/* hw/rtl/cmr_queue.sv */
// ----------------------------------------------------------------------------
// Cost matrix reduction: request queue
// A short first-in first-out buffer of decoded requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
`include "cost_matrix_reduction_defines.svh"

module cmr_queue import cmr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_slot[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage slots carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    `CMR_CHECK(a_count_bound, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
    `CMR_CHECK_IMPL(a_pop_nonempty, i_pop, r_count != '0, "pop from an empty queue")
    `CMR_CHECK_NEXT(a_push_counts, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "push not counted")

endmodule

/* hw/rtl/cmr_back.sv */
// ----------------------------------------------------------------------------
// Cost matrix reduction: back end
// Holds the cell values in a memory and the valid marks in flip-flops,
// carries out writes, reads, cross-outs and the two-pass reduction, and
// drives the registered result channel.
// ----------------------------------------------------------------------------
`include "cost_matrix_reduction_defines.svh"

module cmr_back import cmr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [SIZE_W-1:0]   i_cfg_wr_data,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TOTAL_W-1:0]  o_result_value,
    output logic                o_result_valid
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MIN   = 5'b00010,
        ST_SUB   = 5'b00100,
        ST_RDATA = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [SIZE_W-1:0]    r_size_in_use;
    logic [CELL_N-1:0]    r_cell_valid, n_cell_valid;
    logic [VALUE_W-1:0]   mem [CELL_N];
    logic [VALUE_W-1:0]   r_mem_q;

    logic                 r_pass_col, n_pass_col;
    logic [CNT_W-1:0]     r_line, n_line;
    logic [CNT_W-1:0]     r_k, n_k;
    logic                 r_pend, n_pend;
    logic                 r_pend_vld, n_pend_vld;
    logic [ADDR_W-1:0]    r_pend_addr, n_pend_addr;
    logic                 r_found, n_found;
    logic [VALUE_W-1:0]   r_least, n_least;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic                 r_res_valid, n_res_valid;
    logic                 r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0]   r_out_value, n_out_value;
    logic                 r_out_flag, n_out_flag;

    logic [CNT_W-1:0]     live_n;
    logic [IDX_W-1:0]     line_idx;
    logic [IDX_W-1:0]     k_idx;
    logic [ADDR_W-1:0]    walk_addr;
    logic [CELL_N-1:0]    cross_mask;
    logic [TOTAL_W:0]     sum;
    logic                 out_free;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [VALUE_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    // Size in use, limited to the storage.
    assign live_n = (int'(r_size_in_use) > MAX_SIZE) ? CNT_W'(MAX_SIZE)
                                                     : CNT_W'(r_size_in_use);

    // Address of the current cell along a row or down a column.
    assign line_idx  = r_line[IDX_W-1:0];
    assign k_idx     = r_k[IDX_W-1:0];
    assign walk_addr = r_pass_col
        ? ADDR_W'(ADDR_W'(k_idx) * ADDR_W'(MAX_SIZE) + ADDR_W'(line_idx))
        : ADDR_W'(ADDR_W'(line_idx) * ADDR_W'(MAX_SIZE) + ADDR_W'(k_idx));

    // Cells hit by a cross-out of the queued row and column.
    always_comb begin
        for (int i = 0; i < CELL_N; i++) begin
            cross_mask[i] =
                (i_q_item.row_in && (i / MAX_SIZE) == int'(i_q_item.row)
                                 && (i % MAX_SIZE) < int'(live_n)) ||
                (i_q_item.col_in && (i % MAX_SIZE) == int'(i_q_item.col)
                                 && (i / MAX_SIZE) < int'(live_n));
        end
    end

    // Running total with saturation.
    assign sum      = {1'b0, r_total} + (TOTAL_W+1)'(r_least);
    assign out_free = !r_out_valid || !i_out_stall;

    // Command sequencer.
    always_comb begin
        n_state      = r_state;
        n_cell_valid = r_cell_valid;
        n_pass_col   = r_pass_col;
        n_line       = r_line;
        n_k          = r_k;
        n_pend       = 1'b0;
        n_pend_vld   = r_pend_vld;
        n_pend_addr  = r_pend_addr;
        n_found      = r_found;
        n_least      = r_least;
        n_total      = r_total;
        n_res_valid  = r_res_valid;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_flag   = r_out_flag;
        o_q_pop      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_pend_addr;
        mem_wdata    = r_mem_q - r_least;
        mem_raddr    = walk_addr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.op)
                        OP_WRITE: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                if (i_q_item.row_in && i_q_item.col_in) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = i_q_item.addr;
                                    mem_wdata = i_q_item.value;
                                    n_cell_valid[i_q_item.addr] = i_q_item.entry_valid;
                                end
                                n_out_valid = 1'b1;
                                n_out_value = '0;
                                n_out_flag  = 1'b0;
                            end
                        end
                        OP_CROSS: begin
                            if (out_free) begin
                                o_q_pop      = 1'b1;
                                n_cell_valid = r_cell_valid & ~cross_mask;
                                n_out_valid  = 1'b1;
                                n_out_value  = '0;
                                n_out_flag   = 1'b0;
                            end
                        end
                        OP_READ: begin
                            o_q_pop     = 1'b1;
                            mem_raddr   = i_q_item.addr;
                            n_res_valid = i_q_item.row_in && i_q_item.col_in
                                          && r_cell_valid[i_q_item.addr];
                            n_state     = ST_RDATA;
                        end
                        OP_REDUCE: begin
                            o_q_pop     = 1'b1;
                            n_total     = '0;
                            n_res_valid = 1'b0;
                            n_pass_col  = 1'b0;
                            n_line      = '0;
                            n_k         = '0;
                            n_found     = 1'b0;
                            n_state     = (live_n == '0) ? ST_DONE : ST_MIN;
                        end
                        default: ;
                    endcase
                end
            end

            ST_RDATA: begin
                n_total = r_res_valid ? TOTAL_W'(r_mem_q) : '0;
                n_state = ST_DONE;
            end

            ST_MIN, ST_SUB: begin
                // Fold in the cell that was read last cycle, or write it back less the minimum.
                if (r_state == ST_MIN) begin
                    if (r_pend && r_pend_vld && (!r_found || r_mem_q < r_least)) begin
                        n_least = r_mem_q;
                        n_found = 1'b1;
                    end
                end else if (r_pend && r_pend_vld) begin
                    mem_we = 1'b1;
                end

                // Issue the next read along the line.
                if (r_k < live_n) begin
                    n_pend      = 1'b1;
                    n_pend_vld  = r_cell_valid[walk_addr];
                    n_pend_addr = walk_addr;
                    n_k         = r_k + 1'b1;
                end

                // End of a walk over one line.
                if (r_k == live_n && !r_pend) begin
                    n_k = '0;
                    if (r_state == ST_MIN && r_found) begin
                        n_total = (sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                                  : sum[TOTAL_W-1:0];
                        n_state = ST_SUB;
                    end else begin
                        n_found = 1'b0;
                        if (CNT_W'(r_line + 1'b1) == live_n) begin
                            n_line = '0;
                            if (!r_pass_col) begin
                                n_pass_col = 1'b1;
                                n_state    = ST_MIN;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end else begin
                            n_line  = r_line + 1'b1;
                            n_state = ST_MIN;
                        end
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_total;
                    n_out_flag  = r_res_valid;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_size_in_use <= SIZE_RESET;
            r_cell_valid  <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cell_valid <= n_cell_valid;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_size_in_use <= i_cfg_wr_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pass_col  <= n_pass_col;
        r_line      <= n_line;
        r_k         <= n_k;
        r_pend_vld  <= n_pend_vld;
        r_pend_addr <= n_pend_addr;
        r_found     <= n_found;
        r_least     <= n_least;
        r_total     <= n_total;
        r_res_valid <= n_res_valid;
        r_out_value <= n_out_value;
        r_out_flag  <= n_out_flag;
    end

    // Cell value memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_valid = r_out_flag;

    `CMR_CHECK_IMPL(a_walk_bound, r_state == ST_MIN || r_state == ST_SUB, r_k <= live_n, "walk past line")
    `CMR_CHECK_IMPL(a_sub_write, mem_we && r_state != ST_IDLE, r_state == ST_SUB && r_pend && r_pend_vld, "stray memory write")
    `CMR_CHECK_IMPL(a_pop_idle, o_q_pop, r_state == ST_IDLE, "request taken while busy")

endmodule

/* hw/rtl/cost_matrix_reduction.sv */
// ----------------------------------------------------------------------------
// Cost matrix reduction
// Reduced-cost-matrix engine for branch-and-bound tour search: a square
// matrix of costs with valid marks, written, read, crossed out and reduced.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         i_in_valid / o_in_stall   cmd, row, col, value, valid
//   result    out        o_out_valid / i_out_stall result value, result valid
//   config    in         i_cfg_wr_en               size in use
//
// Each request answers one result: write and cross-out straight from idle, a
// read through the read-data and done states. A reduce walks each line once
// for its minimum and, if it holds a valid cell, once more to subtract it,
// through the one read port of the cell value memory. Reset clears all valid
// marks and sets the size in use to 16. A two-entry queue keeps requests coming
// while the back end works; a stalled result holds writes, cross-outs and done.
// ----------------------------------------------------------------------------
module cost_matrix_reduction import cmr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [SIZE_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [ROW_W-1:0]    i_row_index,
    input  logic [ROW_W-1:0]    i_col_index,
    input  logic [VALUE_W-1:0]  i_entry_value,
    input  logic                i_entry_valid,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TOTAL_W-1:0]  o_result_value,
    output logic                o_result_valid
);

    logic  q_ready;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    t_item push_item;
    t_item pop_item;

    // Decode of incoming requests.
    cmr_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_entry_value (i_entry_value),
        .i_entry_valid (i_entry_valid),
        .i_q_ready     (q_ready),
        .o_q_push      (q_push),
        .o_q_item      (push_item)
    );

    // Buffer between decode and execution.
    cmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    // Matrix storage and command execution.
    cmr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_q_valid      (q_valid),
        .i_q_item       (pop_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_result_valid (o_result_valid)
    );

endmodule
